[rtl/itai_pkg.sv]
// Package with shared types and constants for the IMU time-align interpolation unit.
package itai_pkg;

  localparam int unsigned MaxDepth  = 64;
  localparam int unsigned SlotW     = $clog2(MaxDepth);
  localparam int unsigned CountW    = SlotW + 1;
  localparam int unsigned NumVal    = 9;
  localparam int unsigned ValIdxW   = 4;
  localparam int unsigned ValAddrW  = $clog2(MaxDepth * NumVal);
  localparam int unsigned StampW    = 48;
  localparam int unsigned MinGapUs  = 1000;
  localparam int unsigned FracW     = 16;

  typedef enum logic [2:0] {
    KindInterp   = 3'd0,
    KindOldest   = 3'd1,
    KindNewFresh = 3'd2,
    KindNewStale = 3'd3,
    KindEmpty    = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    FuncPush  = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  localparam logic [1:0] RegDepth = 2'd0;
  localparam logic [1:0] RegStale = 2'd1;

  typedef struct packed {
    logic               func;
    logic [StampW-1:0]  stamp;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic [StampW-1:0]  out_stamp;
    logic signed [31:0] out_gyro_x;
    logic signed [31:0] out_gyro_y;
    logic signed [31:0] out_gyro_z;
    logic signed [31:0] out_accel_x;
    logic signed [31:0] out_accel_y;
    logic signed [31:0] out_accel_z;
    logic signed [31:0] out_angle_x;
    logic signed [31:0] out_angle_y;
    logic signed [31:0] out_angle_z;
    logic [2:0]         match_kind;
  } out_item_t;

  // Handshake between the sequencer and the fraction divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

[rtl/imu_time_align_interpolate_unit.sv]
// Top level of the IMU time-align interpolation unit: ring buffer, scan and blend.
// A push writes the stamp and the nine values into the ring, one value written per cycle.
// A query scans the stored stamps from the oldest; to interpolate it then reads the earlier
// stamp, runs the fraction divider and blends each value with the shared blend multiplier.
// Otherwise, or when the two stamps lie too close, a stored sample is copied value by value.
// The scan reads the stamp memory one entry at a time and the divider is bit-serial.
// Reset clears the ring to empty and loads depth 64 and stale limit 20000 us.
module imu_time_align_interpolate_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  itai_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output itai_pkg::out_item_t   out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned SW = itai_pkg::SlotW;
  localparam int unsigned CW = itai_pkg::CountW;
  localparam int unsigned TW = itai_pkg::StampW;
  localparam int unsigned AW = itai_pkg::ValAddrW;

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StPush   = 12'b000000000010,
    StScanRd = 12'b000000000100,
    StScanCk = 12'b000000001000,
    StPrevRd = 12'b000000010000,
    StPrevCk = 12'b000000100000,
    StDiv    = 12'b000001000000,
    StValRdA = 12'b000010000000,
    StValRdB = 12'b000100000000,
    StMul    = 12'b001000000000,
    StCopy   = 12'b010000000000,
    StOut    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [6:0]  depth_q;
  logic [23:0] stale_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 7'd64;
      stale_q <= 24'd20000;
    end else if (wr_en) begin
      case (paddr[2])
        itai_pkg::RegDepth[0]: depth_q <= pwdata[6:0];
        default:               stale_q <= pwdata[23:0];
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      itai_pkg::RegDepth[0]: prdata = {25'd0, depth_q};
      default:               prdata = {8'd0, stale_q};
    endcase
  end

  logic [CW-1:0] eff_depth;
  always_comb begin
    eff_depth = depth_q;
    if (depth_q == 7'd0) eff_depth = 7'd1;
    if (depth_q > 7'(itai_pkg::MaxDepth)) eff_depth = 7'(itai_pkg::MaxDepth);
  end

  // Ring state.
  logic [SW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] fill_q, fill_d;

  // Working registers.
  itai_pkg::in_item_t  item_q, item_d;
  itai_pkg::out_item_t res_q, res_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [3:0]          k_q, k_d;
  logic [TW-1:0]       t2_q, t2_d, t1_q, t1_d;
  logic [SW-1:0]       slot_q, slot_d, prev_q, prev_d;
  logic                out_valid_q, out_valid_d;
  logic signed [31:0]  va_q, va_d;
  logic signed [48:0]  acc_q, acc_d;
  logic                copy_q, copy_d;

  // Memories.
  logic          st_we;
  logic [SW-1:0] st_addr;
  logic [TW-1:0] st_rdata;
  logic          vl_we;
  logic [AW-1:0] vl_addr;
  logic [31:0]   vl_wdata, vl_rdata;

  itai_ram #(.Width(TW), .Depth(itai_pkg::MaxDepth)) u_stamp_ram (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(item_q.stamp), .rdata_o(st_rdata)
  );
  itai_ram #(.Width(32), .Depth(itai_pkg::MaxDepth * itai_pkg::NumVal)) u_value_ram (
    .clk_i, .we_i(vl_we), .addr_i(vl_addr), .wdata_i(vl_wdata), .rdata_o(vl_rdata)
  );

  // Divider.
  itai_pkg::div_ctrl_t     div_ctrl;
  logic                    div_done;
  logic [itai_pkg::FracW-1:0] frac;
  logic                    div_started_q, div_started_d;
  itai_div u_div (
    .clk_i, .rst_ni, .ctrl_i(div_ctrl),
    .num_i(item_q.stamp - t1_q), .den_i(t2_q - t1_q),
    .done_o(div_done), .frac_o(frac)
  );

  logic [287:0] in_vals;
  assign in_vals = {item_q.gyro_x, item_q.gyro_y, item_q.gyro_z,
                    item_q.accel_x, item_q.accel_y, item_q.accel_z,
                    item_q.angle_x, item_q.angle_y, item_q.angle_z};

  function automatic logic [AW-1:0] vaddr(logic [SW-1:0] s, logic [3:0] k);
    logic [AW-1:0] base;
    base = AW'(s) * AW'(itai_pkg::NumVal);
    return base + AW'(k);
  endfunction

  logic [16:0]        wa, wb;
  logic [SW-1:0]      scan_slot;

  assign scan_slot = SW'(oldest_q + SW'(idx_q));
  assign wa        = 17'd65536 - {1'b0, frac};
  assign wb        = {1'b0, frac};

  always_comb begin
    state_d       = state_q;
    oldest_d      = oldest_q;
    fill_d        = fill_q;
    item_d        = item_q;
    res_d         = res_q;
    idx_d         = idx_q;
    k_d           = k_q;
    t1_d          = t1_q;
    t2_d          = t2_q;
    slot_d        = slot_q;
    prev_d        = prev_q;
    out_valid_d   = out_valid_q;
    va_d          = va_q;
    acc_d         = acc_q;
    copy_d        = copy_q;
    div_started_d = div_started_q;
    st_we         = 1'b0;
    st_addr       = slot_q;
    vl_we         = 1'b0;
    vl_addr       = vaddr(slot_q, k_q);
    vl_wdata      = in_vals[287 - 32*k_q -: 32];
    div_ctrl      = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && !out_valid_q) begin
          item_d = in_data_i;
          k_d    = '0;
          idx_d  = '0;
          if (in_data_i.func == itai_pkg::FuncPush) begin
            slot_d  = SW'(oldest_q + SW'(fill_q));
            state_d = StPush;
          end else if (fill_q == '0) begin
            res_d            = '0;
            res_d.match_kind = itai_pkg::KindEmpty;
            state_d          = StOut;
          end else begin
            state_d = StScanRd;
          end
        end
      end
      StPush: begin
        st_we = (k_q == 4'd0);
        vl_we = 1'b1;
        k_d   = k_q + 4'd1;
        if (k_q == 4'(itai_pkg::NumVal - 1)) begin
          if (fill_q < eff_depth) fill_d = fill_q + CW'(1);
          else oldest_d = oldest_q + SW'(1);
          state_d = StIdle;
        end
      end
      StScanRd: begin
        st_addr = scan_slot;
        slot_d  = scan_slot;
        state_d = StScanCk;
      end
      StScanCk: begin
        t2_d = st_rdata;
        if (st_rdata > item_q.stamp) begin
          if (idx_q == '0) begin
            res_d.out_stamp  = st_rdata;
            res_d.match_kind = itai_pkg::KindOldest;
            copy_d  = 1'b1;
            state_d = StValRdA;
          end else begin
            prev_d  = slot_q - SW'(1);
            state_d = StPrevRd;
          end
        end else if (idx_q + CW'(1) == fill_q) begin
          res_d.out_stamp  = st_rdata;
          res_d.match_kind = ({1'b0, item_q.stamp} > {1'b0, st_rdata} &&
                              ({1'b0, item_q.stamp} - {1'b0, st_rdata}) > (TW+1)'(stale_q))
                             ? itai_pkg::KindNewStale : itai_pkg::KindNewFresh;
          copy_d  = 1'b1;
          state_d = StValRdA;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = StScanRd;
        end
      end
      StPrevRd: begin
        st_addr = prev_q;
        state_d = StPrevCk;
      end
      StPrevCk: begin
        t1_d             = st_rdata;
        res_d.out_stamp  = item_q.stamp;
        res_d.match_kind = itai_pkg::KindInterp;
        if (t2_q - st_rdata < TW'(itai_pkg::MinGapUs)) begin
          slot_d  = prev_q;
          copy_d  = 1'b1;
          state_d = StValRdA;
        end else begin
          copy_d        = 1'b0;
          div_started_d = 1'b0;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        div_ctrl.start = !div_started_q;
        div_ctrl.busy  = !div_started_q;
        div_started_d  = 1'b1;
        if (div_started_q && div_done) begin
          k_d     = '0;
          state_d = StValRdA;
        end
      end
      StValRdA: begin
        // Copy reads the chosen slot; blend reads the earlier sample first.
        vl_addr = vaddr(copy_q ? slot_q : prev_q, k_q);
        state_d = copy_q ? StCopy : StValRdB;
      end
      StCopy: begin
        case (k_q)
          4'd0: res_d.out_gyro_x  = vl_rdata;
          4'd1: res_d.out_gyro_y  = vl_rdata;
          4'd2: res_d.out_gyro_z  = vl_rdata;
          4'd3: res_d.out_accel_x = vl_rdata;
          4'd4: res_d.out_accel_y = vl_rdata;
          4'd5: res_d.out_accel_z = vl_rdata;
          4'd6: res_d.out_angle_x = vl_rdata;
          4'd7: res_d.out_angle_y = vl_rdata;
          default: res_d.out_angle_z = vl_rdata;
        endcase
        k_d     = k_q + 4'd1;
        state_d = (k_q == 4'(itai_pkg::NumVal - 1)) ? StOut : StValRdA;
      end
      StValRdB: begin
        va_d    = vl_rdata;
        vl_addr = vaddr(slot_q, k_q);
        acc_d   = 49'sd32768;
        state_d = StMul;
        div_started_d = 1'b0;
      end
      StMul: begin
        // First pass weights the earlier value, second pass the later one.
        // A zero fraction gives a full weight of 65536, so the weights are kept unsigned.
        if (!div_started_q) begin
          acc_d         = acc_q + 49'(va_q * $signed({1'b0, wa}));
          va_d          = vl_rdata;
          div_started_d = 1'b1;
        end else begin
          acc_d         = acc_q + 49'(va_q * $signed({1'b0, wb}));
          div_started_d = 1'b0;
          case (k_q)
            4'd0: res_d.out_gyro_x  = acc_d[47:16];
            4'd1: res_d.out_gyro_y  = acc_d[47:16];
            4'd2: res_d.out_gyro_z  = acc_d[47:16];
            4'd3: res_d.out_accel_x = acc_d[47:16];
            4'd4: res_d.out_accel_y = acc_d[47:16];
            4'd5: res_d.out_accel_z = acc_d[47:16];
            4'd6: res_d.out_angle_x = acc_d[47:16];
            4'd7: res_d.out_angle_y = acc_d[47:16];
            default: res_d.out_angle_z = acc_d[47:16];
          endcase
          k_d     = k_q + 4'd1;
          state_d = (k_q == 4'(itai_pkg::NumVal - 1)) ? StOut : StValRdA;
        end
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      oldest_q      <= '0;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      div_started_q <= 1'b0;
      copy_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      oldest_q      <= oldest_d;
      fill_q        <= fill_d;
      out_valid_q   <= out_valid_d;
      div_started_q <= div_started_d;
      copy_q        <= copy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    idx_q  <= idx_d;
    k_q    <= k_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    slot_q <= slot_d;
    prev_q <= prev_d;
    va_q   <= va_d;
    acc_q  <= acc_d;
  end

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(itai_pkg::MaxDepth))
    else $error("fill count exceeds ring size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o || $past(out_valid_o))
    else $error("result shown in the cycle after accept");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> out_valid_o)
    else $error("finished result not presented");

endmodule

[rtl/itai_ram.sv]
// Generic single-port RAM with registered read data.
module itai_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/itai_div.sv]
// Restoring divider that forms the Q0.16 interpolation fraction one bit per cycle.
module itai_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  itai_pkg::div_ctrl_t          ctrl_i,
  input  logic [itai_pkg::StampW-1:0]  num_i,
  input  logic [itai_pkg::StampW-1:0]  den_i,
  output logic                         done_o,
  output logic [itai_pkg::FracW-1:0]   frac_o
);

  logic [itai_pkg::StampW:0]     rem_q, rem_d;
  logic [itai_pkg::StampW-1:0]   den_q, den_d;
  logic [itai_pkg::FracW-1:0]    quo_q, quo_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic [itai_pkg::StampW+1:0]   trial;

  // The numerator is below the denominator, so the quotient has only fraction bits.
  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    trial = {rem_q, 1'b0} - {2'b00, den_q};
    if (ctrl_i.start) begin
      rem_d = {1'b0, num_i};
      den_d = den_i;
      cnt_d = 5'(itai_pkg::FracW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[itai_pkg::StampW+1]) begin
        rem_d = trial[itai_pkg::StampW:0];
        quo_d = {quo_q[itai_pkg::FracW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[itai_pkg::StampW-1:0], 1'b0};
        quo_d = {quo_q[itai_pkg::FracW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = !run_q && !ctrl_i.busy;
  assign frac_o = quo_q;

endmodule
